// File: src/srfs_pkg.sv
package srfs_pkg;

    localparam int REG_COUNT_DEFAULT = 256;

    localparam logic [7:0] ABORT_CODE_RESET     = 8'd255;
    localparam logic [7:0] READ_CMD_CODE_RESET  = 8'd1;
    localparam logic [7:0] WRITE_CMD_CODE_RESET = 8'd2;

    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t CFG_ABORT_CODE     = 2'd0;
    localparam cfg_index_t CFG_READ_CMD_CODE  = 2'd1;
    localparam cfg_index_t CFG_WRITE_CMD_CODE = 2'd2;

    typedef logic [1:0] mode_t;
    localparam mode_t MODE_RX_BYTE    = 2'd0;
    localparam mode_t MODE_LOCAL_WR   = 2'd1;
    localparam mode_t MODE_LOCAL_RD   = 2'd2;
    localparam mode_t MODE_TX_SERVICE = 2'd3;

    localparam logic KIND_TX_BYTE = 1'b0;
    localparam logic KIND_LOCAL_RD = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_RD_REG   = 3'd1,
        ST_RD_CNT   = 3'd2,
        ST_WR_REG   = 3'd3,
        ST_WR_CNT   = 3'd4,
        ST_WR_DATA  = 3'd5,
        ST_RD_BURST = 3'd6
    } proto_state_t;

endpackage

// File: src/serial_register_file_slave.sv
// Byte-serial slave in front of a REG_COUNT-byte register file. Each input word is a received
// serial byte, a local write, a local read or a transmit service tick; a local read returns the
// register value and a service tick during a read burst returns the next burst byte (last marks
// the final one). One word is accepted every cycle while the output side keeps up. A result word
// is read through the registered read port of the register file, with kind and last held in a
// stage register beside it, and moves from that stage to the output register once the output
// register is empty or being read; m_valid rises as the result enters the output register.
// While the output register is stalled and the stage holds a result, s_ready is low.
// The register file is ready straight out of reset: per-entry valid flags make unwritten entries
// read as zero, so there is no clearing pass. Configuration writes (abort code, read and write
// command codes) take effect at the next clock edge and must be made while the block is idle.
module serial_register_file_slave #(
    parameter int REG_COUNT = srfs_pkg::REG_COUNT_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_we,
    input  srfs_pkg::cfg_index_t  cfg_index,
    input  logic [7:0]            cfg_wdata,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  srfs_pkg::mode_t       s_mode,
    input  logic [7:0]            s_data_byte,
    input  logic [7:0]            s_local_addr,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_kind,
    output logic [7:0]            m_value,
    output logic                  m_last
);

    localparam int         AW        = $clog2(REG_COUNT);
    localparam logic [8:0] REG_LIMIT = 9'(REG_COUNT);

    // configuration
    logic [7:0] abort_code_reg;
    logic [7:0] read_cmd_code_reg;
    logic [7:0] write_cmd_code_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            abort_code_reg     <= srfs_pkg::ABORT_CODE_RESET;
            read_cmd_code_reg  <= srfs_pkg::READ_CMD_CODE_RESET;
            write_cmd_code_reg <= srfs_pkg::WRITE_CMD_CODE_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                srfs_pkg::CFG_ABORT_CODE:     abort_code_reg     <= cfg_wdata;
                srfs_pkg::CFG_READ_CMD_CODE:  read_cmd_code_reg  <= cfg_wdata;
                srfs_pkg::CFG_WRITE_CMD_CODE: write_cmd_code_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // protocol state
    srfs_pkg::proto_state_t state_reg, state_next;
    logic [7:0] start_reg, start_next;
    logic [7:0] pointer_reg, pointer_next;
    logic [7:0] end_addr_reg, end_addr_next;
    logic [7:0] bytes_left_reg, bytes_left_next;

    // pipeline
    logic       accept;
    logic       p1_valid_reg;
    logic       p1_kind_reg;
    logic       p1_last_reg;
    logic       p1_hit_reg;
    logic       p1_move;
    logic       m_valid_reg;
    logic       m_kind_reg;
    logic [7:0] m_value_reg;
    logic       m_last_reg;

    // register file access
    logic       res_valid;
    logic       res_kind;
    logic       res_last;
    logic       rd_en;
    logic [7:0] rd_addr;
    logic       wr_en;
    logic [7:0] wr_addr;
    logic [7:0] wr_data;
    logic       rd_in_range;
    logic       wr_in_range;
    logic [AW-1:0] rd_idx;
    logic [AW-1:0] wr_idx;
    logic [7:0] mem [REG_COUNT];
    logic [REG_COUNT-1:0] fill_reg;
    logic [7:0] rd_data_reg;

    assign p1_move = p1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !p1_valid_reg || p1_move;
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next      = state_reg;
        start_next      = start_reg;
        pointer_next    = pointer_reg;
        end_addr_next   = end_addr_reg;
        bytes_left_next = bytes_left_reg;
        res_valid       = 1'b0;
        res_kind        = srfs_pkg::KIND_TX_BYTE;
        res_last        = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = s_local_addr;
        wr_en           = 1'b0;
        wr_addr         = s_local_addr;
        wr_data         = s_data_byte;
        if (accept) begin
            case (s_mode)
                srfs_pkg::MODE_RX_BYTE: begin
                    if (s_data_byte == abort_code_reg) begin
                        state_next      = srfs_pkg::ST_IDLE;
                        pointer_next    = start_reg;
                        bytes_left_next = 8'd0;
                    end else begin
                        case (state_reg)
                            srfs_pkg::ST_IDLE: begin
                                if (s_data_byte == read_cmd_code_reg) begin
                                    state_next = srfs_pkg::ST_RD_REG;
                                end else if (s_data_byte == write_cmd_code_reg) begin
                                    state_next = srfs_pkg::ST_WR_REG;
                                end
                            end
                            srfs_pkg::ST_RD_REG: begin
                                start_next   = s_data_byte;
                                pointer_next = s_data_byte;
                                state_next   = srfs_pkg::ST_RD_CNT;
                            end
                            srfs_pkg::ST_RD_CNT: begin
                                bytes_left_next = s_data_byte;
                                state_next      = srfs_pkg::ST_RD_BURST;
                            end
                            srfs_pkg::ST_WR_REG: begin
                                start_next   = s_data_byte;
                                pointer_next = s_data_byte;
                                state_next   = srfs_pkg::ST_WR_CNT;
                            end
                            srfs_pkg::ST_WR_CNT: begin
                                end_addr_next = start_reg + s_data_byte;
                                state_next    = srfs_pkg::ST_WR_DATA;
                            end
                            srfs_pkg::ST_WR_DATA: begin
                                wr_en        = 1'b1;
                                wr_addr      = pointer_reg;
                                pointer_next = pointer_reg + 8'd1;
                                if (pointer_next == end_addr_reg) begin
                                    state_next = srfs_pkg::ST_IDLE;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                srfs_pkg::MODE_LOCAL_WR: begin
                    wr_en = 1'b1;
                end
                srfs_pkg::MODE_LOCAL_RD: begin
                    rd_en     = 1'b1;
                    res_valid = 1'b1;
                    res_kind  = srfs_pkg::KIND_LOCAL_RD;
                end
                srfs_pkg::MODE_TX_SERVICE: begin
                    if (state_reg == srfs_pkg::ST_RD_BURST) begin
                        if (bytes_left_reg == 8'd0) begin
                            state_next = srfs_pkg::ST_IDLE;
                        end else begin
                            rd_en           = 1'b1;
                            rd_addr         = pointer_reg;
                            res_valid       = 1'b1;
                            res_last        = (bytes_left_reg == 8'd1);
                            pointer_next    = pointer_reg + 8'd1;
                            bytes_left_next = bytes_left_reg - 8'd1;
                            if (bytes_left_reg == 8'd1) begin
                                state_next = srfs_pkg::ST_IDLE;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= srfs_pkg::ST_IDLE;
            start_reg      <= 8'd0;
            pointer_reg    <= 8'd0;
            end_addr_reg   <= 8'd0;
            bytes_left_reg <= 8'd0;
        end else begin
            state_reg      <= state_next;
            start_reg      <= start_next;
            pointer_reg    <= pointer_next;
            end_addr_reg   <= end_addr_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

    assign rd_in_range = {1'b0, rd_addr} < REG_LIMIT;
    assign wr_in_range = {1'b0, wr_addr} < REG_LIMIT;
    assign rd_idx      = rd_addr[AW-1:0];
    assign wr_idx      = wr_addr[AW-1:0];

    always_ff @(posedge aclk) begin
        if (wr_en && wr_in_range) begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    // unwritten entries read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (wr_en && wr_in_range) begin
            fill_reg[wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (accept) begin
            p1_valid_reg <= res_valid;
        end else if (p1_move) begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && res_valid) begin
            p1_kind_reg <= res_kind;
            p1_last_reg <= res_last;
            p1_hit_reg  <= rd_in_range && fill_reg[rd_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (p1_move) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_move) begin
            m_kind_reg  <= p1_kind_reg;
            m_last_reg  <= p1_last_reg;
            m_value_reg <= p1_hit_reg ? rd_data_reg : 8'd0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_kind  = m_kind_reg;
    assign m_value = m_value_reg;
    assign m_last  = m_last_reg;

`ifndef SYNTH
    a_out_held_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready)
        |=> (m_valid_reg && $stable(m_kind_reg) && $stable(m_value_reg) && $stable(m_last_reg)))
        else $error("output word changed while stalled");

    a_left_only_in_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        (bytes_left_reg != 8'd0) |-> (state_reg == srfs_pkg::ST_RD_BURST))
        else $error("burst count pending outside read burst");

    a_last_ends_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_mode == srfs_pkg::MODE_TX_SERVICE)
            && (state_reg == srfs_pkg::ST_RD_BURST) && (bytes_left_reg == 8'd1))
        |=> ((state_reg == srfs_pkg::ST_IDLE) && p1_valid_reg && p1_last_reg))
        else $error("final burst word did not end the burst");

    a_local_rd_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_mode == srfs_pkg::MODE_LOCAL_RD))
        |=> (p1_valid_reg && (p1_kind_reg == srfs_pkg::KIND_LOCAL_RD) && !p1_last_reg))
        else $error("local read gave no result");

    a_write_marks_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && wr_in_range) |=> fill_reg[$past(wr_idx)])
        else $error("written entry not marked valid");
`endif

endmodule
